FILE: sv/pwr_pkg.sv
// Package for the particle weight resampler: sizes, opcodes, controller states
// and the particle count clamp.
// No dependencies.
package pwr_pkg;

  // sizing
  localparam int unsigned MAX_PARTICLES = 1024;
  localparam int unsigned IDX_W = $clog2(MAX_PARTICLES);
  localparam int unsigned CNT_W = $clog2(MAX_PARTICLES + 1);
  localparam int unsigned CFG_W = 11;
  localparam int unsigned OUT_W = 10;
  localparam int unsigned WGT_W = 32;
  localparam int unsigned FRAC_W = 32;
  localparam int unsigned SUM_W = 42;
  localparam int unsigned HI_W = SUM_W - FRAC_W;

  // opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOTAL,
    ST_SCALE,
    ST_SEARCH,
    ST_FINISH
  } state_e;

  // register value to effective count: zero acts as one, capped at the maximum
  function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_W-1:0] v);
    int unsigned w;
    w = 32'(v);
    if (w == 0) begin
      w = 1;
    end
    if (w > MAX_PARTICLES) begin
      w = MAX_PARTICLES;
    end
    return CNT_W'(w);
  endfunction

endpackage

FILE: sv/pwr_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module pwr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write or read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/particle_weight_resampler.sv
// Particle weight resampler: prefix-sum memory plus binary-search controller.
// Depends on pwr_pkg and pwr_ram.
//
// Multinomial resampler over cumulative weights. A load beat (opcode 0) adds its
// weight to the running total and stores the total as the next prefix sum in a
// one-port RAM; first restarts the set at index zero, and loads past the
// particle count are dropped. A draw beat (opcode 1) reads the last prefix sum,
// scales the fraction by it in two multiply steps, then binary-searches the RAM
// for the first prefix sum not below the target. Each search step is one RAM
// read; the block takes no new input beat until the draw is done, and each draw
// returns one beat. A result still waiting in the output register holds the
// draw in its finish state for as long as it waits. A draw with nothing loaded
// returns index 0. The user must write the count register only while the block
// is idle; the block itself does not enforce this.
module particle_weight_resampler (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       particle_count_we_i,
  input  logic [pwr_pkg::CFG_W-1:0]  particle_count_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       opcode_i,
  input  logic [pwr_pkg::WGT_W-1:0]  weight_i,
  input  logic                       first_i,
  input  logic [pwr_pkg::FRAC_W-1:0] random_fraction_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [pwr_pkg::OUT_W-1:0]  particle_index_o
);

  import pwr_pkg::*;

  state_e state_q, state_d;

  logic [CFG_W-1:0]    count_q;
  logic [CNT_W-1:0]    loaded_q;
  logic [SUM_W-1:0]    total_q;
  logic [CNT_W-1:0]    n_q;
  logic [CNT_W-1:0]    lo_q, hi_q, mid_q;
  logic [CNT_W-1:0]    idx_q;
  logic [FRAC_W-1:0]   frac_q;
  logic [HI_W-1:0]     tot_hi_q;
  logic [2*FRAC_W-1:0] mul_lo_q;
  logic [SUM_W-1:0]    target_q;
  logic                out_valid_q;
  logic [OUT_W-1:0]    out_idx_q;

  logic                mem_we;
  logic [IDX_W-1:0]    mem_addr;
  logic [SUM_W-1:0]    mem_wdata;
  logic [SUM_W-1:0]    mem_rdata;

  logic [CNT_W-1:0]    cnt;
  logic                accept;
  logic [CNT_W-1:0]    base;
  logic [SUM_W-1:0]    base_total;
  logic                load_ok;
  logic [CNT_W-1:0]    n_draw;
  logic [CNT_W-1:0]    n_last;
  logic                less;
  logic [CNT_W-1:0]    lo_n, hi_n, mid_n;
  logic [CNT_W-1:0]    mid_init;
  logic                out_free;

  // prefix sum storage
  pwr_ram #(
    .WIDTH(SUM_W),
    .DEPTH(MAX_PARTICLES)
  ) u_sums (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  // shared combinational terms
  assign cnt        = eff_count(count_q);
  assign accept     = in_valid_i && !in_stall_o;
  assign base       = first_i ? '0 : loaded_q;
  assign base_total = first_i ? '0 : total_q;
  assign load_ok    = base < cnt;
  assign mem_wdata  = base_total + SUM_W'(weight_i);
  assign n_draw     = (loaded_q < cnt) ? loaded_q : cnt;
  assign n_last     = n_draw - CNT_W'(1);
  assign mid_init   = n_q >> 1;
  assign out_free   = !out_valid_q || !out_stall_i;

  // one search step on the entry read at mid
  assign less  = mem_rdata < target_q;
  assign lo_n  = less ? mid_q + CNT_W'(1) : lo_q;
  assign hi_n  = less ? hi_q : mid_q;
  assign mid_n = lo_n + ((hi_n - lo_n) >> 1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && opcode_i == OP_DRAW) begin
          state_d = (n_draw == '0) ? ST_FINISH : ST_TOTAL;
        end
      end
      ST_TOTAL:  state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_SEARCH;
      ST_SEARCH: begin
        if (!(lo_n < hi_n)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // memory port and handshake outputs
  always_comb begin
    mem_we   = 1'b0;
    mem_addr = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && opcode_i == OP_LOAD) begin
          mem_we   = load_ok;
          mem_addr = base[IDX_W-1:0];
        end else begin
          mem_addr = n_last[IDX_W-1:0];
        end
      end
      ST_SCALE:  mem_addr = mid_init[IDX_W-1:0];
      ST_SEARCH: mem_addr = mid_n[IDX_W-1:0];
      default:   mem_addr = '0;
    endcase
  end

  assign in_stall_o       = state_q != ST_IDLE;
  assign out_valid_o      = out_valid_q;
  assign particle_index_o = out_idx_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= CFG_W'(MAX_PARTICLES);
      loaded_q    <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (particle_count_we_i) begin
        count_q <= particle_count_i;
      end
      // load beat updates the running sum
      if (state_q == ST_IDLE && accept && opcode_i == OP_LOAD) begin
        if (load_ok) begin
          loaded_q <= base + CNT_W'(1);
          total_q  <= mem_wdata;
        end else begin
          loaded_q <= base;
          total_q  <= base_total;
        end
      end
      // output register
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // draw datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        frac_q <= random_fraction_i;
        n_q    <= n_draw;
        idx_q  <= '0;
      end
      ST_TOTAL: begin
        mul_lo_q <= frac_q * mem_rdata[FRAC_W-1:0];
        tot_hi_q <= mem_rdata[SUM_W-1:FRAC_W];
      end
      ST_SCALE: begin
        target_q <= SUM_W'(frac_q) * SUM_W'(tot_hi_q)
                  + SUM_W'(mul_lo_q[2*FRAC_W-1:FRAC_W]);
        lo_q     <= '0;
        hi_q     <= n_q;
        mid_q    <= mid_init;
      end
      ST_SEARCH: begin
        lo_q  <= lo_n;
        hi_q  <= hi_n;
        mid_q <= mid_n;
        idx_q <= (lo_n >= n_q) ? n_q - CNT_W'(1) : lo_n;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_idx_q <= OUT_W'(32'(idx_q));
        end
      end
      default: begin
      end
    endcase
  end

  // checks
  a_loaded_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q <= CNT_W'(MAX_PARTICLES))
    else $error("loaded count above maximum");

  a_draw_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && accept && opcode_i == OP_DRAW) |=> state_q != ST_IDLE)
    else $error("draw beat did not start the search");

  a_mid_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> (lo_q <= mid_q && mid_q < hi_q && hi_q <= n_q))
    else $error("search midpoint out of range");

  a_result_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH && state_d == ST_FINISH) |=> idx_q < n_q)
    else $error("search result beyond loaded particles");

  a_finish_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && out_valid_q && out_stall_i) |=> state_q == ST_FINISH)
    else $error("result dropped while output beat pending");

endmodule

FILE: test/resample_checker.sv
// Checker for the particle weight resampler: tracks loaded weights and the count
// register, predicts the index of every draw beat and compares the output beats.
// Depends on pwr_pkg.
module resample_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       particle_count_we_i,
  input  logic [pwr_pkg::CFG_W-1:0]  particle_count_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic                       opcode_i,
  input  logic [pwr_pkg::WGT_W-1:0]  weight_i,
  input  logic                       first_i,
  input  logic [pwr_pkg::FRAC_W-1:0] random_fraction_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [pwr_pkg::OUT_W-1:0]  particle_index_i,
  output int unsigned                fail_count_o,
  output int unsigned                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import pwr_pkg::*;

  // running prefix sums of the current weight set
  logic [SUM_W-1:0] prefix_mem [MAX_PARTICLES];
  logic [SUM_W-1:0] weight_total;
  int unsigned      loaded_n;
  logic [CFG_W-1:0] count_reg;

  // indexes still owed by the block, oldest first
  logic [OUT_W-1:0] expected_picks [$];
  int unsigned      fails = 0;

  assign fail_count_o = fails;

  // zero behaves as one, anything above the memory size as the memory size
  function automatic int unsigned usable_count(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return 1;
    end
    if (int'(v) > MAX_PARTICLES) begin
      return MAX_PARTICLES;
    end
    return int'(v);
  endfunction

  // append one weight, or restart the set first
  function automatic void take_weight(input logic [WGT_W-1:0] w, input logic restart);
    if (restart) begin
      loaded_n = 0;
      weight_total = '0;
    end
    if (loaded_n < usable_count(count_reg)) begin
      weight_total = weight_total + SUM_W'(w);
      prefix_mem[loaded_n] = weight_total;
      loaded_n++;
    end
  endfunction

  // scale the fraction by the total, then lower bound over the prefix sums
  function automatic logic [OUT_W-1:0] pick_particle(input logic [FRAC_W-1:0] frac);
    int unsigned      n;
    int unsigned      lo;
    int unsigned      hi;
    int unsigned      mid;
    logic [SUM_W-1:0] total;
    logic [63:0]      target;
    n = (loaded_n < usable_count(count_reg)) ? loaded_n : usable_count(count_reg);
    if (n == 0) begin
      return '0;
    end
    total = prefix_mem[n-1];
    target = 64'(frac) * 64'(total >> FRAC_W)
           + ((64'(frac) * 64'(total[FRAC_W-1:0])) >> FRAC_W);
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (64'(prefix_mem[mid]) < target) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    if (lo >= n) begin
      lo = n - 1;
    end
    return OUT_W'(lo);
  endfunction

  // follow config writes and input beats, check output beats
  always @(posedge clk_i or negedge rst_ni) begin
    logic [OUT_W-1:0] want;
    if (!rst_ni) begin
      loaded_n = 0;
      weight_total = '0;
      count_reg = CFG_W'(MAX_PARTICLES);
      expected_picks.delete();
      pending_o <= 0;
    end else begin
      if (particle_count_we_i) begin
        count_reg = particle_count_i;
      end
      if (in_valid_i && !in_stall_i) begin
        if (opcode_i == OP_LOAD) begin
          take_weight(weight_i, first_i);
        end else begin
          expected_picks.push_back(pick_particle(random_fraction_i));
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_picks.size() == 0) begin
          fails++;
          $display("%0t: unexpected beat, expected none, actual particle_index %0d",
                   $time, particle_index_i);
        end else begin
          want = expected_picks.pop_front();
          if (want !== particle_index_i) begin
            fails++;
            $display("%0t: particle_index mismatch, expected %0d, actual %0d",
                     $time, want, particle_index_i);
          end
        end
      end
      pending_o <= expected_picks.size();
    end
  end

endmodule

FILE: test/tb_particle_weight_resampler.sv
// Testbench top for the particle weight resampler: clock, reset, load and draw
// stimulus with bursty sender and stalling receiver, config phases and verdict.
// Depends on pwr_pkg, particle_weight_resampler and resample_checker.
module tb_particle_weight_resampler;
  timeunit 1ns;
  timeprecision 1ps;
  import pwr_pkg::*;

  localparam int unsigned RANDOM_BEATS = 1350;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned IDLE_LIMIT   = 4000;

  logic              clk_i;
  logic              rst_ni;
  logic              particle_count_we_i;
  logic [CFG_W-1:0]  particle_count_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              opcode_i;
  logic [WGT_W-1:0]  weight_i;
  logic              first_i;
  logic [FRAC_W-1:0] random_fraction_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [OUT_W-1:0]  particle_index_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned beats_sent;
  int unsigned burst_left;
  int unsigned hold_reqs = 0;

  particle_weight_resampler i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .particle_count_we_i (particle_count_we_i),
    .particle_count_i    (particle_count_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .opcode_i            (opcode_i),
    .weight_i            (weight_i),
    .first_i             (first_i),
    .random_fraction_i   (random_fraction_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .particle_index_o    (particle_index_o)
  );

  resample_checker i_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .particle_count_we_i (particle_count_we_i),
    .particle_count_i    (particle_count_i),
    .in_valid_i          (in_valid_i),
    .in_stall_i          (in_stall_o),
    .opcode_i            (opcode_i),
    .weight_i            (weight_i),
    .first_i             (first_i),
    .random_fraction_i   (random_fraction_i),
    .out_valid_i         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .particle_index_i    (particle_index_o),
    .fail_count_o        (fail_count),
    .pending_o           (pending)
  );

  // 8 ns clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // weights with extremes and small values mixed in
  function automatic logic [WGT_W-1:0] rand_weight();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return WGT_W'($urandom_range(0, 15));
      3: return WGT_W'($urandom_range(0, 1000));
      default: return WGT_W'($urandom);
    endcase
  endfunction

  // fractions with both ends of [0,1) mixed in
  function automatic logic [FRAC_W-1:0] rand_fraction();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return FRAC_W'(1);
      default: return FRAC_W'($urandom);
    endcase
  endfunction

  // count settings, extremes and out-of-range values included
  function automatic logic [CFG_W-1:0] pick_count();
    case ($urandom_range(0, 11))
      0: return CFG_W'(1);
      1: return '0;
      2: return '1;
      3: return CFG_W'($urandom_range(MAX_PARTICLES, 2047));
      4: return CFG_W'(2);
      default: return CFG_W'($urandom_range(3, 40));
    endcase
  endfunction

  // offer one beat until accepted, then maybe end the burst with a gap
  task automatic send_beat(input logic op, input logic [WGT_W-1:0] w, input logic f,
                           input logic [FRAC_W-1:0] fr);
    int unsigned gap;
    in_valid_i        <= 1'b1;
    opcode_i          <= op;
    weight_i          <= w;
    first_i           <= f;
    random_fraction_i <= fr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 30) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // unused fields carry noise
  task automatic send_load(input logic [WGT_W-1:0] w, input logic restart);
    send_beat(OP_LOAD, w, restart, FRAC_W'($urandom));
  endtask

  task automatic send_draw(input logic [FRAC_W-1:0] fr);
    send_beat(OP_DRAW, WGT_W'($urandom), 1'($urandom_range(0, 1)), fr);
  endtask

  // stop offering, wait for every owed index, then let the block go idle
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [CFG_W-1:0] v);
    particle_count_we_i <= 1'b1;
    particle_count_i    <= v;
    @(posedge clk_i);
    particle_count_we_i <= 1'b0;
  endtask

  // one weight set with draws, or appends, noise or bare draws
  task automatic run_set(input int unsigned eff);
    int unsigned kind;
    int unsigned k;
    int unsigned m;
    kind = $urandom_range(0, 9);
    k = $urandom_range(1, ((eff < 40) ? eff : 40) + 3);
    m = $urandom_range(1, 12);
    if (kind <= 6) begin
      send_load(rand_weight(), 1'b1);
      repeat (k - 1) send_load(rand_weight(), 1'b0);
      repeat (m) send_draw(rand_fraction());
    end else if (kind == 7) begin
      repeat (k) send_load(rand_weight(), 1'b0);
      repeat (m) send_draw(rand_fraction());
    end else if (kind == 8) begin
      repeat (k + m) begin
        if ($urandom_range(0, 1) == 1) begin
          send_draw(rand_fraction());
        end else begin
          send_load(rand_weight(), 1'($urandom_range(0, 4) == 0));
        end
      end
    end else begin
      repeat (m) send_draw(rand_fraction());
    end
  endtask

  // receiver stall pattern, plus long holds on request
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    int unsigned served;
    out_stall_i = 1'b0;
    mode = 0;
    span = 0;
    served = 0;
    forever begin
      @(posedge clk_i);
      if (hold_reqs != served) begin
        served++;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(10, 80);
      end
      span--;
      case (mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 9) < 7);
        default: out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  // end the run when no beat moves on either channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_particle_weight_resampler NOT OK");
    $finish;
  end

  // stimulus
  initial begin
    int unsigned      phase;
    int unsigned      eff;
    logic [CFG_W-1:0] cnt;
    rst_ni              = 1'b0;
    particle_count_we_i = 1'b0;
    particle_count_i    = '0;
    in_valid_i          = 1'b0;
    opcode_i            = OP_LOAD;
    weight_i            = '0;
    first_i             = 1'b0;
    random_fraction_i   = '0;
    beats_sent          = 0;
    burst_left          = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // draw before anything is loaded, then a set whose total is zero
    send_draw('1);
    send_load('0, 1'b1);
    send_draw(FRAC_W'(32'h8000_0000));
    // extreme weights at the reset count
    send_load('1, 1'b1);
    send_load('0, 1'b0);
    send_load('1, 1'b0);
    send_load(WGT_W'(1), 1'b0);
    send_draw('0);
    send_draw('1);
    send_draw(FRAC_W'(32'h8000_0000));
    send_draw(FRAC_W'(1));
    send_draw(FRAC_W'(32'h7FFF_FFFF));
    // count of two, the third load is dropped
    settle();
    write_count(CFG_W'(2));
    send_load(WGT_W'(10), 1'b1);
    send_load(WGT_W'(20), 1'b0);
    send_load('1, 1'b0);
    send_draw('1);
    send_draw(FRAC_W'(32'h5555_5555));
    // count lowered to zero over the loaded pair
    settle();
    write_count('0);
    send_draw('1);
    // count above the memory size
    settle();
    write_count('1);
    send_draw('1);
    send_draw('0);

    // one full set of the largest size, heavy last weight to reach the top index
    settle();
    write_count(CFG_W'(MAX_PARTICLES));
    send_load(WGT_W'($urandom_range(0, 255)), 1'b1);
    repeat (MAX_PARTICLES - 2) begin
      send_load(($urandom_range(0, 15) == 0) ? rand_weight()
                                              : WGT_W'($urandom_range(0, 255)), 1'b0);
    end
    send_load('1, 1'b0);
    send_load(rand_weight(), 1'b0);
    send_draw('1);
    repeat (20) send_draw(rand_fraction());

    // random phases, each under its own count setting
    phase = 0;
    while (beats_sent < RANDOM_BEATS) begin
      settle();
      cnt = pick_count();
      write_count(cnt);
      eff = (cnt == '0) ? 1 : ((int'(cnt) > MAX_PARTICLES) ? MAX_PARTICLES : int'(cnt));
      if (phase == 0) begin
        // long output hold while draws keep coming, the block must back up
        hold_reqs <= hold_reqs + 1;
        send_load(rand_weight(), 1'b1);
        repeat (30) send_draw(rand_fraction());
      end
      repeat ($urandom_range(1, 5)) run_set(eff);
      phase++;
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("tb_particle_weight_resampler OK");
    end else begin
      $display("tb_particle_weight_resampler NOT OK");
    end
    $finish;
  end

endmodule
